### design/sha256_byte_stream_hasher_defines.svh
// Assertion macros for the SHA-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle
`define SHB_ASSERT_IMPL(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
// Assert that a condition implies a consequence in the next cycle
`define SHB_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
`endif

### design/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// Types, constants and round functions shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package shb_pkg;
  localparam int unsigned QueueDepth = 2;
  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
  } core_state_e;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] init_word(input logic [2:0] i);
    init_word = InitHash[(3'd7 - i) * 32 +: 32];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

### design/shb_stream_if.sv
// ----------------------------------------------------------------------------
// shb_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none
interface shb_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/shb_front.sv
// ----------------------------------------------------------------------------
// shb_front
// Accepts input items, drops idle ones and queues the rest for the core.
// ----------------------------------------------------------------------------
`default_nettype none
module shb_front #(
  parameter int unsigned Depth = shb_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire shb_pkg::in_item_t in_item_i,
  output logic                q_valid_o,
  input  wire logic           q_ready_i,
  output shb_pkg::in_item_t   q_item_o
);
  import shb_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t        mem_q [Depth];
  logic [Aw-1:0]   wr_q, rd_q;
  logic [Aw:0]     cnt_q;
  logic            push, pop, useful;

  assign in_ready_o = (cnt_q != Depth[Aw:0]);
  assign useful     = in_item_i.has_byte | in_item_i.is_last;
  assign push       = in_valid_i & in_ready_o & useful;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule
`default_nettype wire

### design/shb_core.sv
// ----------------------------------------------------------------------------
// shb_core
// Block buffer, padding and one-round-per-cycle SHA-256 compression.
// ----------------------------------------------------------------------------
`default_nettype none
module shb_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  output logic                   q_ready_o,
  input  wire shb_pkg::in_item_t q_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output shb_pkg::out_item_t     out_item_o
);
  import shb_pkg::*;
  `include "sha256_byte_stream_hasher_defines.svh"

  // padding applied to the block being loaded
  typedef enum logic [1:0] {
    BLK_PLAIN, BLK_PAD_LEN, BLK_PAD_ONLY, BLK_LEN_ONLY
  } blk_kind_e;

  core_state_e   st_q, st_d;
  blk_kind_e     kind_q, kind_d;
  logic [31:0]   h_q [8];
  logic [31:0]   v_q [8];
  logic [31:0]   w_q [16];   // message schedule window, word 0 in use
  logic [31:0]   blk_q [16]; // block bytes, big-endian within each word
  logic [5:0]    pos_q;
  logic [60:0]   cnt_q;
  logic [5:0]    rnd_q;
  logic [2:0]    oidx_q;
  logic          fin_q;

  logic        take, byte_full, start;
  logic [5:0]  next_pos;
  logic [63:0] bits;

  assign bits      = {cnt_q, 3'b000};
  assign q_ready_o = (st_q == ST_IDLE);
  assign take      = q_valid_i & q_ready_o;
  assign byte_full = take & q_item_i.has_byte & (pos_q == 6'd63);
  assign start     = byte_full | (take & q_item_i.is_last);
  assign next_pos  = q_item_i.has_byte ? pos_q + 6'd1 : pos_q;

  always_comb begin
    st_d   = st_q;
    kind_d = kind_q;
    unique case (st_q)
      ST_IDLE: if (start) begin
        st_d = ST_LOAD;
        if (byte_full) kind_d = BLK_PLAIN;
        else if (next_pos >= 6'd56) kind_d = BLK_PAD_ONLY;
        else kind_d = BLK_PAD_LEN;
      end
      ST_LOAD:  st_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) st_d = ST_ADD;
      ST_ADD: begin
        unique case (kind_q)
          // a finish behind a full block pads a fresh block
          BLK_PLAIN: begin
            if (fin_q) begin
              st_d   = ST_LOAD;
              kind_d = BLK_PAD_LEN;
            end else begin
              st_d = ST_IDLE;
            end
          end
          BLK_PAD_ONLY: begin
            st_d   = ST_LOAD;
            kind_d = BLK_LEN_ONLY;
          end
          default: st_d = ST_EMIT;
        endcase
      end
      ST_EMIT:  if (out_ready_i && oidx_q == 3'd7) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_o            = (st_q == ST_EMIT);
    out_item_o.digest_word = h_q[oidx_q];
    out_item_o.word_index  = oidx_q;
    out_item_o.last_word   = (oidx_q == 3'd7);
  end

  logic [31:0] s1, ch, t1, s0, mj, wn, sg0, sg1;
  assign s1  = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1  = v_q[7] + s1 + ch + round_k(rnd_q) + w_q[0];
  assign s0  = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
  assign mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign sg0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign sg1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wn  = w_q[0] + sg0 + w_q[9] + sg1;

  // buffer byte with padding applied for the block being loaded
  function automatic logic [7:0] pad_byte(input logic [5:0] i, input logic [7:0] b,
                                          input logic [5:0] p, input blk_kind_e k,
                                          input logic [63:0] bl);
    logic [7:0] body;
    logic [7:0] r;
    if (i < p) body = b;
    else if (i == p) body = PadByte;
    else body = 8'h00;
    case (k)
      BLK_PLAIN:    r = b;
      BLK_PAD_ONLY: r = body;
      BLK_PAD_LEN:  r = (i >= 6'd56) ? bl[{3'(6'd63 - i), 3'b000} +: 8] : body;
      default:      r = (i >= 6'd56) ? bl[{3'(6'd63 - i), 3'b000} +: 8] : 8'h00;
    endcase
    pad_byte = r;
  endfunction

  function automatic logic [31:0] pad_word(input logic [3:0] wi, input logic [31:0] word,
                                           input logic [5:0] p, input blk_kind_e k,
                                           input logic [63:0] bl);
    logic [31:0] r;
    for (int j = 0; j < 4; j++)
      r[(3 - j) * 8 +: 8] = pad_byte({wi, 2'(j)}, word[(3 - j) * 8 +: 8], p, k, bl);
    pad_word = r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (take && q_item_i.has_byte)
      blk_q[pos_q[5:2]][{2'd3 - pos_q[1:0], 3'b000} +: 8] <= q_item_i.data_byte;
    if (st_q == ST_LOAD) begin
      for (int i = 0; i < 16; i++) w_q[i] <= pad_word(4'(i), blk_q[i], pos_q, kind_q, bits);
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (st_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + s0 + mj;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; kind_q <= BLK_PLAIN; pos_q <= '0; cnt_q <= '0; rnd_q <= '0;
      oidx_q <= '0; fin_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
    end else begin
      st_q   <= st_d;
      kind_q <= kind_d;
      if (take) begin
        if (q_item_i.has_byte) begin
          pos_q <= pos_q + 6'd1;
          cnt_q <= cnt_q + 61'd1;
        end
        if (start) fin_q <= q_item_i.is_last;
      end
      if (st_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
      if (st_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (st_q == ST_EMIT && out_ready_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
          pos_q <= '0; cnt_q <= '0; fin_q <= 1'b0;
        end
      end
    end
  end

  `SHB_ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, st_q != ST_IDLE, !q_ready_o,
                   "core took an item while busy")
  `SHB_ASSERT_NEXT(a_load_round, clk_i, rst_ni, st_q == ST_LOAD, st_q == ST_ROUND,
                   "load not followed by rounds")
  `SHB_ASSERT_IMPL(a_emit_fin, clk_i, rst_ni, st_q == ST_EMIT, fin_q,
                   "digest emitted without finish")
  `SHB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_item_o), "digest word changed while waiting")
endmodule
`default_nettype wire

### design/sha256_byte_stream_hasher.sv
// A byte that does not fill a block is queued in the front and taken by the core once it
// is idle; a byte that fills a block keeps the core busy for load, 64 rounds and add.
// A finish runs one or two such blocks, then emits 8 words, one per cycle when ready;
// the first word is valid in the emit state that follows the add of the last block.
// While the core hashes a block it takes no bytes; the front queue holds them until full.
// Reset: asynchronous, active low; hash words return to the initial values.
`default_nettype none
module sha256_byte_stream_hasher #(
  parameter int unsigned QDepth = shb_pkg::QueueDepth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  shb_stream_if.sink   in_s,
  shb_stream_if.source out_s
);
  import shb_pkg::*;
  logic     q_valid, q_ready;
  in_item_t q_item;
  out_item_t o_item;

  shb_front #(.Depth(QDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i(in_s.valid), .in_ready_o(in_s.ready),
    .in_item_i(in_s.payload), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item));

  shb_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(out_s.valid), .out_ready_i(out_s.ready), .out_item_o(o_item));

  assign out_s.payload = o_item;
endmodule
`default_nettype wire
